// ----- sv/mm4_pkg.sv -----
package mm4_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_DEF       = 4;

    typedef struct packed {
        logic signed [31:0] left_element;
        logic signed [31:0] right_element;
        logic               last_in;
    } operand_t;

    typedef struct packed {
        logic signed [31:0] product_element;
        logic [3:0]         element_index;
        logic               saturated;
        logic               last_out;
    } result_t;

    // Tag that follows one product term down the multiply-accumulate pipe
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic       final_elem;
        logic [3:0] index;
    } mac_tag_t;

endpackage

// ----- sv/mm4_store.sv -----
module mm4_store #(
    parameter int DIM = 4
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(DIM*DIM)-1:0]        wr_addr,
    input  logic signed [31:0]                wr_left,
    input  logic signed [31:0]                wr_right,
    input  logic [$clog2(DIM*DIM)-1:0]        rd_left_addr,
    input  logic [$clog2(DIM*DIM)-1:0]        rd_right_addr,
    output logic signed [31:0]                rd_left,
    output logic signed [31:0]                rd_right
);
    localparam int CELLS = DIM * DIM;

    logic signed [31:0] left_mem  [CELLS];
    logic signed [31:0] right_mem [CELLS];
    logic signed [31:0] rd_left_reg;
    logic signed [31:0] rd_right_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= wr_left;
            right_mem[wr_addr] <= wr_right;
        end
        rd_left_reg  <= left_mem[rd_left_addr];
        rd_right_reg <= right_mem[rd_right_addr];
    end

    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;

endmodule

// ----- sv/mm4_ctrl.sv -----
module mm4_ctrl #(
    parameter int DIM = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            last_in,
    output logic                            busy,
    output logic                            wr_en,
    output logic [$clog2(DIM*DIM)-1:0]      wr_addr,
    output logic [$clog2(DIM*DIM)-1:0]      rd_left_addr,
    output logic [$clog2(DIM*DIM)-1:0]      rd_right_addr,
    output mm4_pkg::mac_tag_t               issue
);
    import mm4_pkg::*;

    localparam int CELLS  = DIM * DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LOG    = $clog2(DIM);
    localparam logic [LOG-1:0]    LAST_IDX  = LOG'(DIM - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    logic              running_reg, running_next;
    logic [LOG-1:0]    row_reg, row_next;
    logic [LOG-1:0]    col_reg, col_next;
    logic [LOG-1:0]    term_reg, term_next;
    logic [3:0]        elem_reg, elem_next;
    logic [ADDR_W-1:0] load_reg, load_next;
    logic              accept;
    logic              term_last;
    logic              elem_final;

    assign accept     = start && !running_reg;
    assign term_last  = (term_reg == LAST_IDX);
    assign elem_final = term_last && (row_reg == LAST_IDX) && (col_reg == LAST_IDX);

    assign busy    = running_reg;
    assign wr_en   = accept;
    assign wr_addr = load_reg;

    assign rd_left_addr  = ADDR_W'(row_reg * DIM) + ADDR_W'(term_reg);
    assign rd_right_addr = ADDR_W'(term_reg * DIM) + ADDR_W'(col_reg);

    always_comb
    begin
        issue.valid      = running_reg;
        issue.first      = (term_reg == '0);
        issue.last       = term_last;
        issue.final_elem = elem_final;
        issue.index      = elem_reg;
    end

    always_comb
    begin
        running_next = running_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        term_next    = term_reg;
        elem_next    = elem_reg;
        load_next    = load_reg;
        if (accept)
        begin
            if (last_in)
            begin
                load_next    = '0;
                running_next = 1'b1;
                row_next     = '0;
                col_next     = '0;
                term_next    = '0;
                elem_next    = '0;
            end
            else if (load_reg == LAST_CELL)
            begin
                load_next = '0;
            end
            else
            begin
                load_next = load_reg + 1'b1;
            end
        end
        else if (running_reg)
        begin
            // advance one product term per cycle
            if (term_last)
            begin
                term_next = '0;
                elem_next = elem_reg + 1'b1;
                if (col_reg == LAST_IDX)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                if (elem_final)
                begin
                    running_next = 1'b0;
                end
            end
            else
            begin
                term_next = term_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            term_reg    <= '0;
            elem_reg    <= '0;
            load_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            term_reg    <= term_next;
            elem_reg    <= elem_next;
            load_reg    <= load_next;
        end
    end

endmodule

// ----- sv/mm4_mac.sv -----
module mm4_mac #(
    parameter int FRAC_BITS = 16,
    parameter int DIM       = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mm4_pkg::mac_tag_t     issue,
    input  logic signed [31:0]    left_word,
    input  logic signed [31:0]    right_word,
    output logic                  result_valid,
    output mm4_pkg::result_t      result
);
    import mm4_pkg::*;

    localparam int SH_W  = 64 - FRAC_BITS;
    localparam int ACC_W = SH_W + $clog2(DIM) + 1;
    localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-32){1'b1}}, 32'h8000_0000};

    mac_tag_t           tag_rd_reg, tag_mul_reg, tag_acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_shifted;
    logic signed [ACC_W-1:0] term_ext;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic               valid_reg;
    result_t            result_reg, result_next;

    // arithmetic shift rounds toward minus infinity
    assign prod_shifted = prod_reg >>> FRAC_BITS;
    assign term_ext     = ACC_W'($signed(prod_shifted[SH_W-1:0]));
    assign acc_next     = tag_mul_reg.first ? term_ext : acc_reg + term_ext;

    always_comb
    begin
        result_next.element_index = tag_acc_reg.index;
        result_next.last_out      = tag_acc_reg.final_elem;
        if (acc_reg > SAT_MAX)
        begin
            result_next.product_element = 32'sh7FFF_FFFF;
            result_next.saturated       = 1'b1;
        end
        else if (acc_reg < SAT_MIN)
        begin
            result_next.product_element = 32'sh8000_0000;
            result_next.saturated       = 1'b1;
        end
        else
        begin
            result_next.product_element = acc_reg[31:0];
            result_next.saturated       = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= left_word * right_word;
        acc_reg  <= acc_next;
        if (tag_acc_reg.valid && tag_acc_reg.last)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_rd_reg  <= '0;
            tag_mul_reg <= '0;
            tag_acc_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            tag_rd_reg  <= issue;
            tag_mul_reg <= tag_rd_reg;
            tag_acc_reg <= tag_mul_reg;
            valid_reg   <= tag_acc_reg.valid && tag_acc_reg.last;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/matrix4x4_multiply.sv -----
// Operation: an item without last_in is stored into the operand memories; busy stays low.
// An item with last_in is stored too and raises busy for the whole computation, one product
// term per cycle through the single multiply-accumulate unit.
// Each result passes the operand read, product, accumulator and result registers in turn.
// Reset clears the sequencer, load position and pipeline tags; the operand stores
// are not cleared. The receiver cannot stall: each result shows for one cycle.
module matrix4x4_multiply #(
    parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF,
    parameter int DIM       = mm4_pkg::DIM_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mm4_pkg::operand_t    operand,
    output logic                 result_valid,
    output mm4_pkg::result_t     result
);
    import mm4_pkg::*;

    localparam int ADDR_W = $clog2(DIM * DIM);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_left_addr;
    logic [ADDR_W-1:0] rd_right_addr;
    logic signed [31:0] left_word;
    logic signed [31:0] right_word;
    mac_tag_t          issue;

    mm4_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .last_in       (operand.last_in),
        .busy          (busy),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .rd_left_addr  (rd_left_addr),
        .rd_right_addr (rd_right_addr),
        .issue         (issue)
    );

    mm4_store #(
        .DIM (DIM)
    ) u_store (
        .clk           (clk),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_left       (operand.left_element),
        .wr_right      (operand.right_element),
        .rd_left_addr  (rd_left_addr),
        .rd_right_addr (rd_right_addr),
        .rd_left       (left_word),
        .rd_right      (right_word)
    );

    mm4_mac #(
        .FRAC_BITS (FRAC_BITS),
        .DIM       (DIM)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .left_word    (left_word),
        .right_word   (right_word),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
